### hw/rtl/rsfb_pkg.sv
// shared types, constants and elaboration-time functions for the road slope block
// depends on nothing; every other rtl file refers to it by scoped names

package rsfb_pkg;

    localparam int GAIN_W       = 24;
    localparam int MAG_W        = 37;
    localparam int XW           = 58;
    localparam int ROM_W        = 15;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int ASIN_ENTRIES_DEF = 256;
    localparam int QUARTER_TURN = 23040;

    localparam longint ONE_Q36 = 64'sd1 <<< 36;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST = 24'd8388;
    localparam logic [GAIN_W-1:0] DRAG_GAIN_RST  = 24'd315;
    localparam logic [GAIN_W-1:0] ROLL_GAIN_RST  = 24'd10486;
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 24'd1048576;

    typedef enum logic [1:0] {
        REG_DRIVE = 2'd0,
        REG_DRAG  = 2'd1,
        REG_ROLL  = 2'd2,
        REG_ACCEL = 2'd3
    } rsfb_reg_t;

    typedef struct packed {
        logic signed [15:0] torque_nm;
        logic signed [15:0] speed_mps;
        logic signed [15:0] accel_g;
    } rsfb_in_t;

    typedef struct packed {
        logic signed [15:0] slope_deg;
        logic               saturated;
    } rsfb_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0] drive;
        logic [GAIN_W-1:0] drag;
        logic [GAIN_W-1:0] roll;
        logic [GAIN_W-1:0] accel;
    } rsfb_gains_t;

    // classified balance: sign, clamp flag and clamped magnitude in Q.36
    typedef struct packed {
        logic             neg;
        logic             sat;
        logic [MAG_W-1:0] mag;
    } rsfb_cls_t;

    // sine in Q30 of an angle in Q8.8 degrees, series to the 17th power
    function automatic longint sine_q30(longint deg_q8);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (64'(deg_q8) * PI_Q30) / 64'd46080;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
        return sum;
    endfunction

    // arcsine table entry: nearest Q8.8 angle whose sine matches the Q30 target
    function automatic logic [ROM_W-1:0] asin_q8(longint target);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = QUARTER_TURN;
        for (int it = 0; it < 16; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >>> 1;
                if (sine_q30(mid) <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        if (lo < QUARTER_TURN &&
            sine_q30(lo + 1) - target < target - sine_q30(lo)) begin
            lo = lo + 1;
        end
        return ROM_W'(lo);
    endfunction

endpackage

### hw/rtl/rsfb_front.sv
// front pipeline: gain products, force balance, clamp and sign split
// depends on rsfb_pkg; feeds rsfb_queue

module rsfb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rsfb_pkg::rsfb_gains_t gains,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsfb_pkg::rsfb_in_t   s_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output rsfb_pkg::rsfb_cls_t  q_data
);

    localparam int XW = rsfb_pkg::XW;

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;

    logic signed [16:0] speed_ext;
    logic signed [16:0] speed_abs;
    logic signed [9:0]  roll_arg;

    logic signed [40:0] drive1_next, drive1_reg;
    logic signed [31:0] sq1_next, sq1_reg;
    logic signed [34:0] roll1_next, roll1_reg;
    logic signed [40:0] acc1_next, acc1_reg;

    logic signed [55:0]   drag2_next, drag2_reg;
    logic signed [XW-1:0] part2_next, part2_reg;

    logic signed [XW-1:0] x3_next, x3_reg;
    logic signed [XW-1:0] one_q36;
    logic signed [XW-1:0] x_abs;
    logic                 x_sat;

    assign ready3  = !v3_reg || q_ready;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;

    // stage 1: four narrow products
    always_comb begin
        speed_ext = 17'(s_data.speed_mps);
        speed_abs = speed_ext[16] ? -speed_ext : speed_ext;
        priority if (s_data.speed_mps > 16'sd16) begin
            roll_arg = 10'sd256;
        end else if (s_data.speed_mps < -16'sd16) begin
            roll_arg = -10'sd256;
        end else begin
            roll_arg = 10'(s_data.speed_mps) <<< 4;
        end
        drive1_next = $signed({1'b0, gains.drive}) * s_data.torque_nm;
        sq1_next    = s_data.speed_mps * speed_abs;
        roll1_next  = $signed({1'b0, gains.roll}) * roll_arg;
        acc1_next   = $signed({1'b0, gains.accel}) * s_data.accel_g;
    end

    // stage 2: drag product and sum of the other terms
    always_comb begin
        drag2_next = $signed({1'b0, gains.drag}) * sq1_reg;
        part2_next = (XW'(drive1_reg) <<< 8) - (XW'(roll1_reg) <<< 8)
                   - (XW'(acc1_reg) <<< 4);
    end

    // stage 3: full balance
    assign x3_next = part2_reg - XW'(drag2_reg);

    // classify the registered balance into the queue entry
    always_comb begin
        one_q36 = XW'(rsfb_pkg::ONE_Q36);
        x_sat   = (x3_reg > one_q36) || (x3_reg < -one_q36);
        x_abs   = x3_reg[XW-1] ? -x3_reg : x3_reg;
        q_data.neg = x3_reg[XW-1];
        q_data.sat = x_sat;
        q_data.mag = x_sat ? rsfb_pkg::MAG_W'(one_q36) : rsfb_pkg::MAG_W'(x_abs);
    end
    assign q_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            drive1_reg <= drive1_next;
            sq1_reg    <= sq1_next;
            roll1_reg  <= roll1_next;
            acc1_reg   <= acc1_next;
        end
        if (ready2) begin
            drag2_reg <= drag2_next;
            part2_reg <= part2_next;
        end
        if (ready3) begin
            x3_reg <= x3_next;
        end
    end

`ifndef ASSERT_OFF
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !q_ready |=> v3_reg && $stable(x3_reg))
        else $error("front: balance changed while the queue was full");
`endif

endmodule

### hw/rtl/rsfb_queue.sv
// short queue between the front and the back pipelines
// depends on rsfb_pkg for the entry type

module rsfb_queue #(
    parameter int DEPTH = rsfb_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  rsfb_pkg::rsfb_cls_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output rsfb_pkg::rsfb_cls_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rsfb_pkg::rsfb_cls_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          wr_fire, rd_fire;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue: fill count beyond depth");
    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_fire && !rd_fire |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue: push without pop did not grow the count");
`endif

endmodule

### hw/rtl/rsfb_back.sv
// back pipeline: table index, interpolated arcsine, sign and output register
// depends on rsfb_pkg for types and the table functions

module rsfb_back #(
    parameter int ASIN_TABLE_ENTRIES = rsfb_pkg::ASIN_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  rsfb_pkg::rsfb_cls_t q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rsfb_pkg::rsfb_out_t m_data
);

    localparam int IW    = $clog2(ASIN_TABLE_ENTRIES + 1);
    localparam int PW    = rsfb_pkg::MAG_W + IW;
    localparam int ROM_W = rsfb_pkg::ROM_W;

    logic [ROM_W-1:0] rom [ASIN_TABLE_ENTRIES + 1];

    for (genvar gi = 0; gi <= ASIN_TABLE_ENTRIES; gi++) begin : g_rom
        if (gi == 0) begin : g_first
            assign rom[gi] = '0;
        end else if (gi == ASIN_TABLE_ENTRIES) begin : g_last
            assign rom[gi] = ROM_W'(rsfb_pkg::QUARTER_TURN);
        end else begin : g_mid
            localparam longint Target = longint'((64'(gi) << 30) / ASIN_TABLE_ENTRIES);
            assign rom[gi] = rsfb_pkg::asin_q8(Target);
        end
    end

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic ready0, ready1, ready2, ready3;

    logic [PW-1:0]    p_next;
    logic [IW-1:0]    idx0_reg;
    logic [35:0]      frac0_reg;
    logic             neg0_reg, sat0_reg;

    logic             at_top;
    logic [IW-1:0]    hi_addr;
    logic [ROM_W-1:0] base1_next, base1_reg;
    logic [ROM_W-1:0] diff1_next, diff1_reg;
    logic [35:0]      frac1_reg;
    logic             neg1_reg, sat1_reg;

    logic [51:0]      prod;
    logic [15:0]      rnd2_next, rnd2_reg;
    logic [ROM_W-1:0] base2_reg;
    logic             neg2_reg, sat2_reg;

    logic [15:0]         mag_y;
    rsfb_pkg::rsfb_out_t out_next, out_reg;

    assign ready3  = !v3_reg || m_ready;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign ready0  = !v0_reg || ready1;
    assign q_ready = ready0;
    assign m_valid = v3_reg;
    assign m_data  = out_reg;

    // stage 0: scale magnitude by the table size
    assign p_next = PW'(q_data.mag) * PW'(ASIN_TABLE_ENTRIES);

    // stage 1: table reads at idx and idx+1
    always_comb begin
        at_top     = (idx0_reg == IW'(ASIN_TABLE_ENTRIES));
        hi_addr    = at_top ? idx0_reg : IW'(idx0_reg + 1'b1);
        base1_next = rom[idx0_reg];
        diff1_next = at_top ? '0 : ROM_W'(rom[hi_addr] - base1_next);
    end

    // stage 2: interpolation product with rounding
    always_comb begin
        prod      = 52'(diff1_reg) * 52'(frac1_reg) + (52'd1 << 35);
        rnd2_next = prod[51:36];
    end

    // stage 3: add, apply sign
    always_comb begin
        mag_y              = 16'(base2_reg) + rnd2_reg;
        out_next.slope_deg = neg2_reg ? -$signed(mag_y) : $signed(mag_y);
        out_next.saturated = sat2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready0) begin
                v0_reg <= q_valid;
            end
            if (ready1) begin
                v1_reg <= v0_reg;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready0) begin
            idx0_reg  <= p_next[36 +: IW];
            frac0_reg <= p_next[35:0];
            neg0_reg  <= q_data.neg;
            sat0_reg  <= q_data.sat;
        end
        if (ready1) begin
            base1_reg <= base1_next;
            diff1_reg <= diff1_next;
            frac1_reg <= frac0_reg;
            neg1_reg  <= neg0_reg;
            sat1_reg  <= sat0_reg;
        end
        if (ready2) begin
            rnd2_reg  <= rnd2_next;
            base2_reg <= base1_reg;
            neg2_reg  <= neg1_reg;
            sat2_reg  <= sat1_reg;
        end
        if (ready3) begin
            out_reg <= out_next;
        end
    end

endmodule

### hw/rtl/road_slope_from_force_balance.sv
// top level of the road slope estimator: register file, front, queue, back
// depends on rsfb_pkg, rsfb_front, rsfb_queue and rsfb_back

// Road slope from a force balance. Each transfer on the s_ side carries motor
// torque, ground speed and measured acceleration; the block forms
// drive - drag - rolling - inertia in units of g from four gain registers
// (APB, byte addresses 0, 4, 8, 12, unsigned Q4.20 in bits 23:0), clamps the
// balance to +-1 (flagging the clamp in saturated) and returns its arcsine as
// a Q8.8 slope in degrees from an interpolated table of ASIN_TABLE_ENTRIES+1
// points built at elaboration. One item is taken every cycle unless a stall on
// the m_ side has filled the queue; each passes through three front stages
// for the gain products and the balance, the queue, and four back stages for
// table index, table read, interpolation multiply and sign. The four-entry
// queue lets the front keep taking items while the m_ side stalls. There is no
// state kept between items and no clearing pass. Gains are meant to be
// written only while no item is in flight.

module road_slope_from_force_balance #(
    parameter int ASIN_TABLE_ENTRIES = rsfb_pkg::ASIN_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rsfb_pkg::ADDR_W-1:0]  paddr,
    input  logic [rsfb_pkg::DATA_W-1:0]  pwdata,
    output logic [rsfb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rsfb_pkg::rsfb_in_t           s_data,
    // results
    output logic                         m_valid,
    input  logic                         m_ready,
    output rsfb_pkg::rsfb_out_t          m_data
);

    localparam int GAIN_W = rsfb_pkg::GAIN_W;

    rsfb_pkg::rsfb_gains_t gains_reg;
    rsfb_pkg::rsfb_reg_t   reg_sel;
    logic                  cfg_we;

    rsfb_pkg::rsfb_cls_t   fq_data, qb_data;
    logic                  fq_valid, fq_ready;
    logic                  qb_valid, qb_ready;

    // register index from the word address
    assign reg_sel = rsfb_pkg::rsfb_reg_t'(paddr[rsfb_pkg::ADDR_W-1:2]);
    // no wait states
    assign pready  = 1'b1;
    // write lands in the access phase
    assign cfg_we  = psel && penable && pwrite && pready;

    // read back, upper bits read as zero
    always_comb begin
        unique case (reg_sel)
            rsfb_pkg::REG_DRIVE: prdata = rsfb_pkg::DATA_W'(gains_reg.drive);
            rsfb_pkg::REG_DRAG:  prdata = rsfb_pkg::DATA_W'(gains_reg.drag);
            rsfb_pkg::REG_ROLL:  prdata = rsfb_pkg::DATA_W'(gains_reg.roll);
            rsfb_pkg::REG_ACCEL: prdata = rsfb_pkg::DATA_W'(gains_reg.accel);
        endcase
    end

    // gain registers, only bits 23:0 of the write data are kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.drive <= rsfb_pkg::DRIVE_GAIN_RST;
            gains_reg.drag  <= rsfb_pkg::DRAG_GAIN_RST;
            gains_reg.roll  <= rsfb_pkg::ROLL_GAIN_RST;
            gains_reg.accel <= rsfb_pkg::ACCEL_GAIN_RST;
        end else if (cfg_we) begin
            unique case (reg_sel)
                rsfb_pkg::REG_DRIVE: gains_reg.drive <= pwdata[GAIN_W-1:0];
                rsfb_pkg::REG_DRAG:  gains_reg.drag  <= pwdata[GAIN_W-1:0];
                rsfb_pkg::REG_ROLL:  gains_reg.roll  <= pwdata[GAIN_W-1:0];
                rsfb_pkg::REG_ACCEL: gains_reg.accel <= pwdata[GAIN_W-1:0];
            endcase
        end
    end

    // front: products, balance, clamp and sign
    rsfb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .gains   (gains_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    // queue decouples the two pipelines
    rsfb_queue #(
        .DEPTH (rsfb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // back: interpolated arcsine and output register
    rsfb_back #(
        .ASIN_TABLE_ENTRIES (ASIN_TABLE_ENTRIES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_sat_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.slope_deg == 16'(rsfb_pkg::QUARTER_TURN) ||
             m_data.slope_deg == -16'(rsfb_pkg::QUARTER_TURN)))
        else $error("top: clamped balance did not give a quarter turn");
    a_slope_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.slope_deg <= $signed(16'(rsfb_pkg::QUARTER_TURN)) &&
                     m_data.slope_deg >= -$signed(16'(rsfb_pkg::QUARTER_TURN))))
        else $error("top: slope beyond a quarter turn");
`endif

endmodule

### tb/testbench.sv
// self-checking testbench for road_slope_from_force_balance
// drives item transfers and apb gain writes, predicts or looks up every slope and checks it
// depends on rsfb_pkg and the road_slope_from_force_balance rtl only

`timescale 1ns / 1ps

module testbench;

    localparam int ASIN_N       = 256;
    localparam int HOLD_CYCLES  = 64;
    localparam int RUN_ITEMS    = 130;   // items per gain setting in the random part
    localparam int SETTINGS_PER = 5;     // gain settings per idling phase
    localparam int TAIL_CYCLES  = 24;

    localparam logic signed [15:0] SLOPE_UP   = 16'sd23040;
    localparam logic signed [15:0] SLOPE_DOWN = -16'sd23040;

    // gain sets used by the directed rows
    typedef enum logic [1:0] {
        GS_RESET = 2'd0,
        GS_UNIT  = 2'd1,
        GS_MAX   = 2'd2,
        GS_ZERO  = 2'd3
    } gain_set_t;

    // one directed row: gain set, item, and a typed-in result where it is obvious
    typedef struct packed {
        gain_set_t           gset;
        rsfb_pkg::rsfb_in_t  item;
        logic                lit;
        rsfb_pkg::rsfb_out_t want;
    } probe_t;

    localparam probe_t PROBES [25] = '{
        // reset gains: zero, full-scale fields, exact and beyond one g of inertia
        '{GS_RESET, {16'h0000, 16'h0000, 16'h0000}, 1'b1, {16'sd0, 1'b0}},
        '{GS_RESET, {16'h7FFF, 16'h0000, 16'h0000}, 1'b1, {SLOPE_UP, 1'b1}},
        '{GS_RESET, {16'h8000, 16'h0000, 16'h0000}, 1'b1, {SLOPE_DOWN, 1'b1}},
        '{GS_RESET, {16'h0000, 16'h7FFF, 16'h0000}, 1'b1, {SLOPE_DOWN, 1'b1}},
        '{GS_RESET, {16'h0000, 16'h8000, 16'h0000}, 1'b1, {SLOPE_UP, 1'b1}},
        '{GS_RESET, {16'h0000, 16'h0000, 16'h7FFF}, 1'b1, {SLOPE_DOWN, 1'b1}},
        '{GS_RESET, {16'h0000, 16'h0000, 16'h8000}, 1'b1, {SLOPE_UP, 1'b1}},
        '{GS_RESET, {16'h0000, 16'h0000, 16'h1000}, 1'b1, {SLOPE_DOWN, 1'b0}},
        '{GS_RESET, {16'h0000, 16'h0000, 16'hF000}, 1'b1, {SLOPE_UP, 1'b0}},
        '{GS_RESET, {16'h0000, 16'h0000, 16'h1001}, 1'b1, {SLOPE_DOWN, 1'b1}},
        // rolling term around its clamp point, both signs, then drive alone and a mixed item
        '{GS_RESET, {16'h0000, 16'h0001, 16'h0000}, 1'b0, 17'd0},
        '{GS_RESET, {16'h0000, 16'hFFFF, 16'h0000}, 1'b0, 17'd0},
        '{GS_RESET, {16'h0000, 16'h0010, 16'h0000}, 1'b0, 17'd0},
        '{GS_RESET, {16'h0000, 16'h0011, 16'h0000}, 1'b0, 17'd0},
        '{GS_RESET, {16'h0100, 16'h0000, 16'h0000}, 1'b0, 17'd0},
        '{GS_RESET, {16'h7FFF, 16'h4000, 16'h1234}, 1'b0, 17'd0},
        // unit drive gain: balance of exactly one either way, then just over, half and the smallest step
        '{GS_UNIT,  {16'h0100, 16'h0000, 16'h0000}, 1'b1, {SLOPE_UP, 1'b0}},
        '{GS_UNIT,  {16'hFF00, 16'h0000, 16'h0000}, 1'b1, {SLOPE_DOWN, 1'b0}},
        '{GS_UNIT,  {16'h0101, 16'h0000, 16'h0000}, 1'b1, {SLOPE_UP, 1'b1}},
        '{GS_UNIT,  {16'h0080, 16'h0000, 16'h0000}, 1'b0, 17'd0},
        '{GS_UNIT,  {16'h0001, 16'h0000, 16'h0000}, 1'b0, 17'd0},
        // full-scale gains
        '{GS_MAX,   {16'h0000, 16'h0000, 16'h0000}, 1'b1, {16'sd0, 1'b0}},
        '{GS_MAX,   {16'h0001, 16'h0000, 16'h0000}, 1'b0, 17'd0},
        '{GS_MAX,   {16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 17'd0},
        // zero gains leave a level road whatever comes in
        '{GS_ZERO,  {16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, {16'sd0, 1'b0}}
    };

    // dut connections, the driven ones known from time zero
    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [rsfb_pkg::ADDR_W-1:0] paddr   = '0;
    logic [rsfb_pkg::DATA_W-1:0] pwdata  = '0;
    logic [rsfb_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    rsfb_pkg::rsfb_in_t          s_data  = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    rsfb_pkg::rsfb_out_t         m_data;

    // predictor state: gains as last written, and the arcsine lookup
    rsfb_pkg::rsfb_gains_t gains_now = '{drive: rsfb_pkg::DRIVE_GAIN_RST,
                                         drag:  rsfb_pkg::DRAG_GAIN_RST,
                                         roll:  rsfb_pkg::ROLL_GAIN_RST,
                                         accel: rsfb_pkg::ACCEL_GAIN_RST};
    int                    asin_lut [0:ASIN_N];

    // slopes predicted for accepted items, oldest first
    rsfb_pkg::rsfb_out_t slopes_due [$];
    rsfb_pkg::rsfb_out_t slope_head;

    int tx_idle_pct  = 6;
    int rx_idle_pct  = 56;
    int holds_asked  = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int fail_count   = 0;
    int items_in     = 0;
    int slopes_out   = 0;
    int clamped_out  = 0;
    int gain_loads   = 0;

    road_slope_from_force_balance #(
        .ASIN_TABLE_ENTRIES(ASIN_N)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sine of a q8.8 degree angle in q30, taylor series up to the 17th power
    function automatic longint sine_of_deg(longint deg_q8);
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] term;
        longint      acc;
        ang  = (64'(deg_q8) * rsfb_pkg::PI_Q30) / 64'd46080;
        ang2 = (ang * ang) >> 30;
        term = ang;
        acc  = longint'(ang);
        for (int k = 1; k <= 8; k++) begin
            term = ((term * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    // lookup entry i: nearest q8.8 angle whose sine is i/ASIN_N, ends pinned
    initial begin
        longint target;
        longint lo;
        longint hi;
        longint mid;
        for (int i = 0; i <= ASIN_N; i++) begin
            target = longint'((64'(i) << 30) / 64'(ASIN_N));
            lo = 0;
            hi = rsfb_pkg::QUARTER_TURN;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (sine_of_deg(mid) <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            if (lo < rsfb_pkg::QUARTER_TURN &&
                sine_of_deg(lo + 1) - target < target - sine_of_deg(lo)) begin
                lo = lo + 1;
            end
            asin_lut[i] = int'(lo);
        end
        asin_lut[0]      = 0;
        asin_lut[ASIN_N] = rsfb_pkg::QUARTER_TURN;
    end

    // force balance in q.36 g, clamp to one g, interpolated arcsine
    function automatic rsfb_pkg::rsfb_out_t predict_slope(rsfb_pkg::rsfb_in_t it);
        longint              trq;
        longint              spd;
        longint              acc;
        longint              spd_abs;
        longint              roll;
        longint              bal;
        longint              mag;
        longint              ang;
        logic [63:0]         pos;
        logic [63:0]         idx;
        logic [63:0]         frac;
        rsfb_pkg::rsfb_out_t res;
        trq     = longint'(it.torque_nm);
        spd     = longint'(it.speed_mps);
        acc     = longint'(it.accel_g);
        spd_abs = (spd < 0) ? -spd : spd;
        roll    = spd * 16;
        if (roll > 256) begin
            roll = 256;
        end
        if (roll < -256) begin
            roll = -256;
        end
        bal = longint'(gains_now.drive) * trq * 256
            - longint'(gains_now.drag) * (spd * spd_abs)
            - longint'(gains_now.roll) * roll * 256
            - longint'(gains_now.accel) * acc * 16;
        res.saturated = 1'b0;
        if (bal > rsfb_pkg::ONE_Q36) begin
            bal = rsfb_pkg::ONE_Q36;
            res.saturated = 1'b1;
        end else if (bal < -rsfb_pkg::ONE_Q36) begin
            bal = -rsfb_pkg::ONE_Q36;
            res.saturated = 1'b1;
        end
        mag  = (bal < 0) ? -bal : bal;
        pos  = 64'(mag) * 64'(ASIN_N);
        idx  = pos >> 36;
        frac = pos & ((64'd1 << 36) - 64'd1);
        if (idx >= 64'(ASIN_N)) begin
            ang = asin_lut[ASIN_N];
        end else begin
            ang = asin_lut[idx] + longint'((64'(asin_lut[idx + 1] - asin_lut[idx]) * frac
                                            + (64'd1 << 35)) >> 36);
        end
        if (bal < 0) begin
            ang = -ang;
        end
        res.slope_deg = 16'(ang);
        return res;
    endfunction

    // mostly log-spread magnitudes so the balance often lands inside one g,
    // the rest raw 16-bit noise on every field
    function automatic rsfb_pkg::rsfb_in_t random_item();
        rsfb_pkg::rsfb_in_t it;
        it = 48'({$urandom, $urandom});
        if ($urandom_range(9) > 2) begin
            it.torque_nm = $signed(it.torque_nm) >>> $urandom_range(14);
            it.speed_mps = $signed(it.speed_mps) >>> $urandom_range(14);
            it.accel_g   = $signed(it.accel_g) >>> $urandom_range(14);
        end
        return it;
    endfunction

    // gain choice: zero, full scale, raw random, or the nominal value rescaled
    function automatic logic [rsfb_pkg::GAIN_W-1:0] pick_gain(
        logic [rsfb_pkg::GAIN_W-1:0] nominal);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return rsfb_pkg::GAIN_W'($urandom);
            default: return rsfb_pkg::GAIN_W'((32'(nominal) << $urandom_range(3))
                                              >> $urandom_range(3));
        endcase
    endfunction

    // apb write, junk in the unused upper data bits
    task automatic reg_write(rsfb_pkg::rsfb_reg_t r, logic [rsfb_pkg::GAIN_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {8'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (r)
            rsfb_pkg::REG_DRIVE: gains_now.drive = val;
            rsfb_pkg::REG_DRAG:  gains_now.drag  = val;
            rsfb_pkg::REG_ROLL:  gains_now.roll  = val;
            rsfb_pkg::REG_ACCEL: gains_now.accel = val;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // apb read, gain bits compared with the predictor's copy
    task automatic reg_readback(rsfb_pkg::rsfb_reg_t r);
        logic [rsfb_pkg::GAIN_W-1:0] held;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (r)
            rsfb_pkg::REG_DRIVE: held = gains_now.drive;
            rsfb_pkg::REG_DRAG:  held = gains_now.drag;
            rsfb_pkg::REG_ROLL:  held = gains_now.roll;
            default:             held = gains_now.accel;
        endcase
        if (prdata[rsfb_pkg::GAIN_W-1:0] !== held) begin
            $error("%s: expected %h, got %h", r.name(), held,
                   prdata[rsfb_pkg::GAIN_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // gains change only with nothing in flight; every result out means idle
    task automatic load_gains(rsfb_pkg::rsfb_gains_t g);
        s_valid <= 1'b0;
        while (slopes_due.size() != 0) @(posedge aclk);
        reg_write(rsfb_pkg::REG_DRIVE, g.drive);
        reg_write(rsfb_pkg::REG_DRAG, g.drag);
        reg_write(rsfb_pkg::REG_ROLL, g.roll);
        reg_write(rsfb_pkg::REG_ACCEL, g.accel);
        for (int r = 0; r < 4; r++) begin
            reg_readback(rsfb_pkg::rsfb_reg_t'(r));
        end
        gain_loads++;
    endtask

    // one input transfer, random gaps ahead of it; the slope due is queued on accept
    task automatic send_item(rsfb_pkg::rsfb_in_t it, logic lit, rsfb_pkg::rsfb_out_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        slopes_due.push_back(lit ? want : predict_slope(it));
        items_in++;
    endtask

    // result side: random stalls, plus a long hold-off on request that lets
    // the queue fill and push back on s_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every result transfer is matched against the oldest slope due
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (slopes_due.size() == 0) begin
                $error("result with nothing due: slope_deg %0d saturated %0b",
                       m_data.slope_deg, m_data.saturated);
                fail_count++;
            end else begin
                slope_head = slopes_due.pop_front();
                if (m_data.slope_deg !== slope_head.slope_deg) begin
                    $error("slope_deg: expected %0d, got %0d",
                           slope_head.slope_deg, m_data.slope_deg);
                    fail_count++;
                end
                if (m_data.saturated !== slope_head.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           slope_head.saturated, m_data.saturated);
                    fail_count++;
                end
                slopes_out++;
                if (m_data.saturated === 1'b1) begin
                    clamped_out++;
                end
            end
        end
    end

    // stimulus
    initial begin
        gain_set_t             cur_set;
        rsfb_pkg::rsfb_gains_t g;
        int                    run;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // gains read back at their reset values before anything is written
        for (int r = 0; r < 4; r++) begin
            reg_readback(rsfb_pkg::rsfb_reg_t'(r));
        end

        // directed rows, gains reloaded whenever the row's set changes
        cur_set = GS_RESET;
        foreach (PROBES[i]) begin
            if (PROBES[i].gset != cur_set) begin
                cur_set = PROBES[i].gset;
                case (cur_set)
                    GS_UNIT: g = '{drive: 24'h100000, drag: '0, roll: '0, accel: '0};
                    GS_MAX:  g = '{drive: '1, drag: '1, roll: '1, accel: '1};
                    GS_ZERO: g = '0;
                    default: g = '{drive: rsfb_pkg::DRIVE_GAIN_RST,
                                   drag:  rsfb_pkg::DRAG_GAIN_RST,
                                   roll:  rsfb_pkg::ROLL_GAIN_RST,
                                   accel: rsfb_pkg::ACCEL_GAIN_RST};
                endcase
                load_gains(g);
            end
            send_item(PROBES[i].item, PROBES[i].lit, PROBES[i].want);
        end

        // random part: three idling phases, several gain settings in each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 56;
                end
                1: begin
                    tx_idle_pct = 56;
                    rx_idle_pct = 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int sub = 0; sub < SETTINGS_PER; sub++) begin
                run = ph * SETTINGS_PER + sub;
                if (run == 0) begin
                    g = '{drive: rsfb_pkg::DRIVE_GAIN_RST,
                          drag:  rsfb_pkg::DRAG_GAIN_RST,
                          roll:  rsfb_pkg::ROLL_GAIN_RST,
                          accel: rsfb_pkg::ACCEL_GAIN_RST};
                end else if (run == 1) begin
                    g = '{drive: '1, drag: '1, roll: '1, accel: '1};
                end else if (run == 7) begin
                    g = '0;
                end else begin
                    g.drive = pick_gain(rsfb_pkg::DRIVE_GAIN_RST);
                    g.drag  = pick_gain(rsfb_pkg::DRAG_GAIN_RST);
                    g.roll  = pick_gain(rsfb_pkg::ROLL_GAIN_RST);
                    g.accel = pick_gain(rsfb_pkg::ACCEL_GAIN_RST);
                end
                load_gains(g);
                if (sub == 2) begin
                    holds_asked++;
                end
                repeat (RUN_ITEMS) begin
                    send_item(random_item(), 1'b0, '0);
                end
            end
        end
        s_valid <= 1'b0;

        // let the last slopes drain, then a few more cycles for strays
        while (slopes_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d item transfers and %0d checked slopes, %0d of them clamped",
                 items_in, slopes_out, clamped_out);
        $display("gains loaded %0d times incl. zero, full scale and reset; %0d long stalls",
                 gain_loads, holds_asked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #(2_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
